// ===== hdl/dwpa_pkg.sv =====
// dwpa_pkg: types and constants shared by the diamond window averaging block.
// No dependencies; every other file of the block but dwpa_ram imports it.
package dwpa_pkg;

  // Sample and grid geometry
  localparam int VALUE_BITS    = 24;
  localparam int COORD_BITS    = 6;
  localparam int DIM_BITS      = 7;
  localparam int RAD_BITS      = 4;
  localparam int CNT_BITS      = 9;
  localparam int GRID_X_MAX    = 64;
  localparam int GRID_Y_MAX    = 64;
  localparam int RADIUS_MAX    = 15;
  localparam int ADDR_BITS     = 2 * COORD_BITS;
  localparam int STORE_DEPTH   = GRID_X_MAX * GRID_Y_MAX;
  localparam int SUM_BITS      = VALUE_BITS + CNT_BITS;
  localparam int CNT_LIMIT     = 2 * RADIUS_MAX * (RADIUS_MAX + 1) + 1;

  // Configuration port
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [RAD_BITS-1:0] RADIUS_RST = 4'd3;
  localparam logic [DIM_BITS-1:0] WIDTH_RST  = 7'd64;
  localparam logic [DIM_BITS-1:0] HEIGHT_RST = 7'd64;

  typedef struct packed {
    logic                          mode;
    logic [COORD_BITS-1:0]         cell_x;
    logic [COORD_BITS-1:0]         cell_y;
    logic signed [VALUE_BITS-1:0]  value_a;
    logic signed [VALUE_BITS-1:0]  value_b;
    logic signed [VALUE_BITS-1:0]  value_c;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  mean_a;
    logic signed [VALUE_BITS-1:0]  mean_b;
    logic signed [VALUE_BITS-1:0]  mean_c;
    logic [CNT_BITS-1:0]           cell_count;
  } out_item_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] smooth_radius;
    logic [DIM_BITS-1:0] grid_width;
    logic [DIM_BITS-1:0] grid_height;
  } cfg_regs_t;

endpackage

// ===== hdl/dwpa_ram.sv =====
// dwpa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dwpa_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dwpa_cfg.sv =====
// dwpa_cfg: APB-style configuration registers (radius, grid width, grid height).
// Depends on dwpa_pkg.
module dwpa_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dwpa_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [dwpa_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [dwpa_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output dwpa_pkg::cfg_regs_t                  regs
);
  import dwpa_pkg::*;

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign regs    = regs_r;

  // Register writes on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.smooth_radius <= RADIUS_RST;
      regs_r.grid_width    <= WIDTH_RST;
      regs_r.grid_height   <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIUS: regs_r.smooth_radius <= pwdata[RAD_BITS-1:0];
        REG_WIDTH:  regs_r.grid_width    <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT: regs_r.grid_height   <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_RADIUS: prdata = CFG_DATA_BITS'(regs_r.smooth_radius);
      REG_WIDTH:  prdata = CFG_DATA_BITS'(regs_r.grid_width);
      REG_HEIGHT: prdata = CFG_DATA_BITS'(regs_r.grid_height);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== hdl/dwpa_div.sv =====
// dwpa_div: shared signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on dwpa_pkg. The quotient is known to fit VALUE_BITS bits.
module dwpa_div (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic signed [dwpa_pkg::SUM_BITS-1:0]     dividend,
  input  logic [dwpa_pkg::CNT_BITS-1:0]            divisor,
  output logic                                     busy,
  output logic                                     done,
  output logic signed [dwpa_pkg::VALUE_BITS-1:0]   quotient
);
  import dwpa_pkg::*;

  localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_BITS-1:0]  step_r;
  logic                  neg_r;
  logic [CNT_BITS-1:0]   dsr_r;
  logic [CNT_BITS-1:0]   rem_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [SUM_BITS-1:0]   dvd_u;
  logic [SUM_BITS-1:0]   mag;
  logic [CNT_BITS:0]     trial;
  logic [CNT_BITS:0]     diff;
  logic                  fits;
  logic [CNT_BITS-1:0]   rem_nxt;

  // Magnitude of the dividend
  assign dvd_u = dividend;
  assign mag   = dvd_u[SUM_BITS-1] ? (~dvd_u + 1'b1) : dvd_u;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial   = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign fits    = trial >= {1'b0, dsr_r};
  assign rem_nxt = fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(VALUE_BITS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: upper bits of |dividend| start below the divisor, so only
  // the low VALUE_BITS bits need a step each
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dvd_u[SUM_BITS-1];
      dsr_r <= divisor;
      rem_r <= mag[SUM_BITS-1 -: CNT_BITS];
      quo_r <= mag[VALUE_BITS-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[VALUE_BITS-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? signed'(~quo_r + 1'b1) : signed'(quo_r);

endmodule

// ===== hdl/diamond_window_point_average.sv =====
// diamond_window_point_average: diamond neighborhood mean over a stored sample grid.
// Write item: stored in the sample store, no result. Query: a setup step, then per column a
// setup step and one store read per cell, a drain step, then the three means in turn in
// the shared divider (one quotient bit a cycle), then the result goes to the output register.
// Not ready while a query is in work; a finished result waits in the output register.
// rst_n (synchronous) clears control state and sets registers to their reset values;
// the sample store is not cleared. Depends on dwpa_pkg, dwpa_ram, dwpa_cfg, dwpa_div.
module diamond_window_point_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dwpa_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dwpa_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dwpa_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dwpa_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dwpa_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import dwpa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_COL   = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] COMP_A = 2'd0;
  localparam logic [1:0] COMP_B = 2'd1;
  localparam logic [1:0] COMP_C = 2'd2;

  cfg_regs_t cfg;

  logic [2:0]             state_r;
  logic [2:0]             state_nxt;
  logic [COORD_BITS-1:0]  cx_r;
  logic [COORD_BITS-1:0]  cy_r;
  logic [COORD_BITS-1:0]  x_r;
  logic [COORD_BITS-1:0]  y_r;
  logic [COORD_BITS-1:0]  i_r;
  logic [COORD_BITS-1:0]  xe_r;
  logic [COORD_BITS-1:0]  j_r;
  logic [COORD_BITS-1:0]  ye_r;
  logic                   rd_vld_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic signed [SUM_BITS-1:0] sum_a_r;
  logic signed [SUM_BITS-1:0] sum_b_r;
  logic signed [SUM_BITS-1:0] sum_c_r;
  logic [1:0]             comp_r;
  logic                   div_started_r;
  logic signed [VALUE_BITS-1:0] mean_a_r;
  logic signed [VALUE_BITS-1:0] mean_b_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [DIM_BITS-1:0]    nx;
  logic [DIM_BITS-1:0]    ny;
  logic [RAD_BITS-1:0]    rad;
  logic [COORD_BITS-1:0]  rad6;
  logic [COORD_BITS-1:0]  x_sat;
  logic [COORD_BITS-1:0]  y_sat;
  logic [COORD_BITS-1:0]  xs;
  logic [DIM_BITS-1:0]    x_hi;
  logic [COORD_BITS-1:0]  xe;
  logic [COORD_BITS-1:0]  dx_abs;
  logic [DIM_BITS-1:0]    y_lo_base;
  logic [COORD_BITS-1:0]  ys;
  logic [DIM_BITS-1:0]    y_hi;
  logic [COORD_BITS-1:0]  ye;

  logic                   in_xfer;
  logic                   wr_en;
  logic                   rd_en;
  logic [3*VALUE_BITS-1:0] rd_data;
  logic signed [VALUE_BITS-1:0] rd_a;
  logic signed [VALUE_BITS-1:0] rd_b;
  logic signed [VALUE_BITS-1:0] rd_c;

  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic signed [SUM_BITS-1:0]   div_dividend;
  logic signed [VALUE_BITS-1:0] div_quo;
  logic                   out_load;

  // Configuration registers
  dwpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  // Sample store: a, b, c packed in one word, address {x, y}
  dwpa_ram #(
    .WIDTH (3 * VALUE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({in_data.cell_x, in_data.cell_y}),
    .wdata ({in_data.value_a, in_data.value_b, in_data.value_c}),
    .re    (rd_en),
    .raddr ({i_r, j_r}),
    .rdata (rd_data)
  );

  // Shared divider for the three means
  dwpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Input handshake
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign wr_en    = in_xfer && (in_data.mode == MODE_WRITE);
  assign rd_en    = (state_r == S_ROW);

  // Effective grid size and radius
  always_comb begin
    if (cfg.grid_width == '0) begin
      nx = DIM_BITS'(1);
    end else if (cfg.grid_width > DIM_BITS'(GRID_X_MAX)) begin
      nx = DIM_BITS'(GRID_X_MAX);
    end else begin
      nx = cfg.grid_width;
    end
    if (cfg.grid_height == '0) begin
      ny = DIM_BITS'(1);
    end else if (cfg.grid_height > DIM_BITS'(GRID_Y_MAX)) begin
      ny = DIM_BITS'(GRID_Y_MAX);
    end else begin
      ny = cfg.grid_height;
    end
    if (cfg.smooth_radius > RAD_BITS'(RADIUS_MAX)) begin
      rad = RAD_BITS'(RADIUS_MAX);
    end else begin
      rad = cfg.smooth_radius;
    end
  end

  assign rad6 = COORD_BITS'(rad);

  // Query setup: saturate the center, clip the column range
  assign x_sat = ({1'b0, cx_r} < nx) ? cx_r : COORD_BITS'(nx - 1'b1);
  assign y_sat = ({1'b0, cy_r} < ny) ? cy_r : COORD_BITS'(ny - 1'b1);
  assign xs    = (x_sat >= rad6) ? (x_sat - rad6) : '0;
  assign x_hi  = DIM_BITS'(x_sat) + DIM_BITS'(rad);
  assign xe    = (x_hi > nx - 1'b1) ? COORD_BITS'(nx - 1'b1) : COORD_BITS'(x_hi);

  // Column setup: row range from the saturated center, then clipped
  assign dx_abs    = (i_r > x_r) ? (i_r - x_r) : (x_r - i_r);
  assign y_lo_base = DIM_BITS'(y_r) + DIM_BITS'(dx_abs);
  assign ys        = (y_lo_base >= DIM_BITS'(rad)) ?
                     COORD_BITS'(y_lo_base - DIM_BITS'(rad)) : '0;
  assign y_hi      = DIM_BITS'(y_r) + DIM_BITS'(rad) - DIM_BITS'(dx_abs);
  assign ye        = (y_hi > ny - 1'b1) ? COORD_BITS'(ny - 1'b1) : COORD_BITS'(y_hi);

  // Read data split
  assign rd_a = rd_data[3*VALUE_BITS-1 -: VALUE_BITS];
  assign rd_b = rd_data[2*VALUE_BITS-1 -: VALUE_BITS];
  assign rd_c = rd_data[VALUE_BITS-1:0];

  // Divider operand select
  always_comb begin
    unique case (comp_r)
      COMP_A:  div_dividend = sum_a_r;
      COMP_B:  div_dividend = sum_b_r;
      default: div_dividend = sum_c_r;
    endcase
  end

  assign div_start = (state_r == S_DIV) && !div_started_r && !div_busy;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.mode == MODE_QUERY)) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: state_nxt = S_COL;
      S_COL:   state_nxt = S_ROW;
      S_ROW: begin
        if (j_r == ye_r) begin
          state_nxt = (i_r == xe_r) ? S_DRAIN : S_COL;
        end
      end
      S_DRAIN: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done && (comp_r == COMP_C)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_vld_r      <= 1'b0;
      div_started_r <= 1'b0;
      comp_r        <= COMP_A;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (state_r == S_DRAIN) begin
        comp_r        <= COMP_A;
        div_started_r <= 1'b0;
      end else if (div_start) begin
        div_started_r <= 1'b1;
      end else if (div_done) begin
        div_started_r <= 1'b0;
        comp_r        <= comp_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and accumulate datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cx_r <= in_data.cell_x;
      cy_r <= in_data.cell_y;
    end
    unique case (state_r)
      S_SETUP: begin
        x_r  <= x_sat;
        y_r  <= y_sat;
        i_r  <= xs;
        xe_r <= xe;
      end
      S_COL: begin
        j_r  <= ys;
        ye_r <= ye;
      end
      S_ROW: begin
        j_r <= j_r + 1'b1;
        if (j_r == ye_r) begin
          i_r <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (state_r == S_SETUP) begin
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_c_r <= '0;
      cnt_r   <= '0;
    end else if (rd_vld_r) begin
      sum_a_r <= sum_a_r + SUM_BITS'(rd_a);
      sum_b_r <= sum_b_r + SUM_BITS'(rd_b);
      sum_c_r <= sum_c_r + SUM_BITS'(rd_c);
      cnt_r   <= cnt_r + 1'b1;
    end
    if (div_done) begin
      unique case (comp_r)
        COMP_A:  mean_a_r <= div_quo;
        COMP_B:  mean_b_r <= div_quo;
        default: ;
      endcase
    end
    // Last quotient stays on the divider output until the result is loaded
    if (out_load) begin
      out_r.mean_a     <= mean_a_r;
      out_r.mean_b     <= mean_b_r;
      out_r.mean_c     <= div_quo;
      out_r.cell_count <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW) |-> (j_r <= ye_r))
    else $error("row index past end of column");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != '0))
    else $error("divide with zero cell count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_BITS'(CNT_LIMIT)))
    else $error("cell count above diamond size");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

endmodule
